[src/tcch_pkg.sv]
`default_nettype none
package tcch_pkg;

  // Field widths
  localparam int W_RAW  = 16;
  localparam int W_BIAS = 48;
  localparam int W_IDX  = 4;
  localparam int W_HEAD = 15;

  // Configuration register indexes
  typedef enum logic [W_IDX-1:0] {
    CFG_ACC_BIAS = 4'd0,
    CFG_MAG_BIAS = 4'd1,
    CFG_MIN_X    = 4'd2,
    CFG_MIN_Y    = 4'd3,
    CFG_MIN_Z    = 4'd4,
    CFG_MAX_X    = 4'd5,
    CFG_MAX_Y    = 4'd6,
    CFG_MAX_Z    = 4'd7
  } cfg_idx_t;

  // Span divider: numerator 2m-min-max, denominator max-min
  localparam int W_NUM     = 19;
  localparam int W_DEN     = 17;
  localparam int W_DN      = 31;   // |num| << 14
  localparam int W_DD      = 16;   // |den|
  localparam int FRAC_M    = 14;
  localparam int DIV_STEPS = 16;
  localparam int LAT_DIV   = DIV_STEPS + 2;
  localparam logic [W_DD-1:0] Q_POS_MAX = 16'd32767;
  localparam logic [W_DD-1:0] Q_NEG_MAX = 16'd32768;

  // Magnitude of a in Q8
  localparam int W_SQ      = 32;
  localparam int W_SQIN    = 48;
  localparam int W_ROOT    = 24;
  localparam int LAT_SQRT  = W_ROOT + 2;

  // Cross products and CORDIC operands
  localparam int W_PROD = 32;
  localparam int W_C    = 33;
  localparam int W_M    = 49;
  localparam int W_NY   = 50;
  localparam int W_XY   = 58;
  localparam int W_CR   = 60;
  localparam int W_ANG  = 26;
  localparam int CORDIC_STEPS = 23;
  localparam int LAT_CORDIC   = CORDIC_STEPS + 2;

  localparam logic signed [W_ANG-1:0] QUARTER_Q16   = 26'sd5898240;
  localparam logic signed [W_ANG-1:0] FULL_TURN_Q16 = 26'sd23592960;
  localparam logic [W_HEAD:0]         TURN_Q6       = 16'd23040;
  localparam int ROUND_SHIFT = 10;
  localparam logic [W_ANG-1:0] ROUND_HALF = 26'd512;

  // Pipeline positions (edges after acceptance)
  localparam int K_S1   = 1;
  localparam int K_Q    = K_S1 + LAT_DIV;
  localparam int K_PROD = K_Q + 1;
  localparam int K_C    = K_Q + 2;
  localparam int K_M    = K_Q + 3;
  localparam int K_NY   = K_Q + 4;
  localparam int K_AMAG = K_S1 + LAT_SQRT;
  localparam int K_XY   = K_AMAG + 1;
  localparam int K_OUT  = K_XY + LAT_CORDIC;

  // Data carried alongside the divider
  typedef struct packed {
    logic [2:0][W_RAW-1:0] a;
    logic                  deg;
  } side_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [W_ANG-1:0] atan_q16(input int i);
    logic signed [W_ANG-1:0] v;
    case (i)
      0:  v = 26'sd2949120;
      1:  v = 26'sd1740967;
      2:  v = 26'sd919879;
      3:  v = 26'sd466945;
      4:  v = 26'sd234379;
      5:  v = 26'sd117304;
      6:  v = 26'sd58666;
      7:  v = 26'sd29335;
      8:  v = 26'sd14668;
      9:  v = 26'sd7334;
      10: v = 26'sd3667;
      11: v = 26'sd1833;
      12: v = 26'sd917;
      13: v = 26'sd458;
      14: v = 26'sd229;
      15: v = 26'sd115;
      16: v = 26'sd57;
      17: v = 26'sd29;
      18: v = 26'sd14;
      19: v = 26'sd7;
      20: v = 26'sd4;
      21: v = 26'sd2;
      22: v = 26'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

[src/tcch_div.sv]
`default_nettype none
module tcch_div (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [tcch_pkg::W_NUM-1:0] num,
  input  wire logic signed [tcch_pkg::W_DEN-1:0] den,
  output logic signed [tcch_pkg::W_RAW-1:0]      q
);
  import tcch_pkg::*;

  logic [W_NUM-1:0] n_mag;
  logic [W_DEN-1:0] d_mag;
  logic [W_DN-1:0]  n_abs;
  logic [W_DD-1:0]  d_abs;
  logic             ovf_nxt;

  logic [W_DN-1:0] rem_r [DIV_STEPS+1];
  logic [W_DD-1:0] den_r [DIV_STEPS+1];
  logic [W_DD-1:0] quo_r [DIV_STEPS+1];
  logic            neg_r [DIV_STEPS+1];
  logic            ovf_r [DIV_STEPS+1];
  logic signed [W_RAW-1:0] q_r;

  // Take magnitudes, scale the numerator, flag a quotient of 2^16 or more
  always_comb begin
    n_mag   = num[W_NUM-1] ? W_NUM'(-num) : W_NUM'(num);
    d_mag   = den[W_DEN-1] ? W_DEN'(-den) : W_DEN'(den);
    n_abs   = {n_mag[W_DN-FRAC_M-1:0], {FRAC_M{1'b0}}};
    d_abs   = d_mag[W_DD-1:0];
    ovf_nxt = ({1'b0, n_abs} >= {d_abs, {W_DD{1'b0}}});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= n_abs;
      den_r[0] <= d_abs;
      quo_r[0] <= '0;
      neg_r[0] <= num[W_NUM-1] ^ den[W_DEN-1];
      ovf_r[0] <= ovf_nxt;
    end
  end

  // One quotient bit per stage, most significant first
  for (genvar j = 1; j <= DIV_STEPS; j++) begin : g_step
    localparam int K = DIV_STEPS - j;
    logic [W_DN:0] trial;
    assign trial = {1'b0, rem_r[j-1]} - ({1'b0, W_DN'(den_r[j-1])} << K);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j] <= trial[W_DN] ? rem_r[j-1] : trial[W_DN-1:0];
        quo_r[j] <= quo_r[j-1] | ({{(W_DD-1){1'b0}}, ~trial[W_DN]} << K);
        den_r[j] <= den_r[j-1];
        neg_r[j] <= neg_r[j-1];
        ovf_r[j] <= ovf_r[j-1];
      end
    end
  end

  // Apply sign and saturate to 16 bits
  always_ff @(posedge clk) begin
    if (en) begin
      if (neg_r[DIV_STEPS]) begin
        q_r <= (ovf_r[DIV_STEPS] || quo_r[DIV_STEPS] > Q_NEG_MAX) ?
               $signed(Q_NEG_MAX) : $signed(W_RAW'(-quo_r[DIV_STEPS]));
      end else begin
        q_r <= (ovf_r[DIV_STEPS] || quo_r[DIV_STEPS] > Q_POS_MAX) ?
               $signed(Q_POS_MAX) : $signed(quo_r[DIV_STEPS]);
      end
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

[src/tcch_sqrt.sv]
`default_nettype none
module tcch_sqrt (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic signed [tcch_pkg::W_RAW-1:0] ax,
  input  wire logic signed [tcch_pkg::W_RAW-1:0] ay,
  input  wire logic signed [tcch_pkg::W_RAW-1:0] az,
  output logic [tcch_pkg::W_ROOT-1:0]            root
);
  import tcch_pkg::*;

  logic [W_SQ-1:0]   sq_r [3];
  logic [W_SQ-1:0]   sum_nxt;
  logic [W_SQIN-1:0] rem_r  [W_ROOT+1];
  logic [W_ROOT-1:0] root_r [W_ROOT+1];

  // Square each axis
  always_ff @(posedge clk) begin
    if (en) begin
      sq_r[0] <= W_SQ'(ax * ax);
      sq_r[1] <= W_SQ'(ay * ay);
      sq_r[2] <= W_SQ'(az * az);
    end
  end

  // Sum and scale to Q16 for a Q8 root
  assign sum_nxt = sq_r[0] + sq_r[1] + sq_r[2];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0]  <= {sum_nxt, 16'b0};
      root_r[0] <= '0;
    end
  end

  // One root bit per stage
  for (genvar j = 1; j <= W_ROOT; j++) begin : g_step
    localparam int K = W_ROOT - j;
    logic [W_SQIN+1:0] t;
    logic [W_SQIN+1:0] trial;
    assign t     = ((W_SQIN+2)'(root_r[j-1]) << (K + 1)) | ((W_SQIN+2)'(1) << (2 * K));
    assign trial = {2'b0, rem_r[j-1]} - t;
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[j]  <= trial[W_SQIN+1] ? rem_r[j-1] : trial[W_SQIN-1:0];
        root_r[j] <= root_r[j-1] | ({{(W_ROOT-1){1'b0}}, ~trial[W_SQIN+1]} << K);
      end
    end
  end

  assign root = root_r[W_ROOT];

endmodule
`default_nettype wire

[src/tcch_cordic.sv]
`default_nettype none
module tcch_cordic (
  input  wire logic                             clk,
  input  wire logic                             en,
  input  wire logic signed [tcch_pkg::W_XY-1:0] x,
  input  wire logic signed [tcch_pkg::W_XY-1:0] y,
  input  wire logic                             deg_in,
  output logic [tcch_pkg::W_HEAD-1:0]           heading,
  output logic                                  deg_out
);
  import tcch_pkg::*;

  logic signed [W_CR-1:0]  xe, ye, x0_nxt, y0_nxt;
  logic signed [W_ANG-1:0] ang0_nxt;

  logic signed [W_CR-1:0]  x_r   [CORDIC_STEPS+1];
  logic signed [W_CR-1:0]  y_r   [CORDIC_STEPS+1];
  logic signed [W_ANG-1:0] ang_r [CORDIC_STEPS+1];
  logic                    deg_r [CORDIC_STEPS+1];

  logic signed [W_ANG-1:0] ang_f;
  logic [W_ANG-1:0]        ang_pos, ang_rnd;
  logic [W_HEAD:0]         h_raw;
  logic [W_HEAD-1:0]       h_nxt, head_r;
  logic                    deg_o_r;

  // Turn the left half plane by a quarter turn
  always_comb begin
    xe       = W_CR'(x);
    ye       = W_CR'(y);
    x0_nxt   = xe;
    y0_nxt   = ye;
    ang0_nxt = '0;
    if (xe < 0) begin
      if (ye >= 0) begin
        x0_nxt   = ye;
        y0_nxt   = -xe;
        ang0_nxt = QUARTER_Q16;
      end else begin
        x0_nxt   = -ye;
        y0_nxt   = xe;
        ang0_nxt = -QUARTER_Q16;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]   <= x0_nxt;
      y_r[0]   <= y0_nxt;
      ang_r[0] <= ang0_nxt;
      deg_r[0] <= deg_in;
    end
  end

  // Vectoring steps: rotate toward y = 0
  for (genvar j = 1; j <= CORDIC_STEPS; j++) begin : g_step
    localparam int I = j - 1;
    localparam logic signed [W_ANG-1:0] ATN = atan_q16(I);
    logic signed [W_CR-1:0] dx, dy;
    assign dx = y_r[j-1] >>> I;
    assign dy = x_r[j-1] >>> I;
    always_ff @(posedge clk) begin
      if (en) begin
        if (y_r[j-1] >= 0) begin
          x_r[j]   <= x_r[j-1] + dx;
          y_r[j]   <= y_r[j-1] - dy;
          ang_r[j] <= ang_r[j-1] + ATN;
        end else begin
          x_r[j]   <= x_r[j-1] - dx;
          y_r[j]   <= y_r[j-1] + dy;
          ang_r[j] <= ang_r[j-1] - ATN;
        end
        deg_r[j] <= deg_r[j-1];
      end
    end
  end

  // Wrap to a positive angle, round to 1/64 degree, fold a full turn to zero
  always_comb begin
    ang_f   = ang_r[CORDIC_STEPS];
    ang_pos = (ang_f < 0) ? W_ANG'(ang_f + FULL_TURN_Q16) : W_ANG'(ang_f);
    ang_rnd = ang_pos + ROUND_HALF;
    h_raw   = (W_HEAD+1)'(ang_rnd >> ROUND_SHIFT);
    h_nxt   = (h_raw >= TURN_Q6) ? W_HEAD'(h_raw - TURN_Q6) : W_HEAD'(h_raw);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      head_r  <= deg_r[CORDIC_STEPS] ? '0 : h_nxt;
      deg_o_r <= deg_r[CORDIC_STEPS];
    end
  end

  assign heading = head_r;
  assign deg_out = deg_o_r;

endmodule
`default_nettype wire

[src/tilt_compensated_compass_heading.sv]
// Tilt-compensated compass heading. Each word carries one raw accelerometer
// and one raw magnetometer sample (three signed 16-bit axes each) and yields
// one heading in 1/64 degree, 0 to 359.98, plus a degenerate flag that is set
// (with a heading of zero) when the span is zero on a magnetometer axis, the
// acceleration is zero, or the field and gravity give no horizontal heading.
// The datapath is a fully pipelined chain of a 16-bit restoring divider per
// axis, a bit-per-stage square root, the cross products and a 23-step CORDIC;
// it takes a new word every cycle unless the output stalls. A stalled output
// freezes the whole pipeline, so in_ready follows out_ready once the output
// register is full. The user must write biases and calibration limits through
// the cfg port while no word is in flight; the block does not enforce this.
`default_nettype none
module tilt_compensated_compass_heading (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               cfg_we,
  input  wire logic [tcch_pkg::W_IDX-1:0]         cfg_index,
  input  wire logic [tcch_pkg::W_BIAS-1:0]        cfg_wdata,
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic signed [tcch_pkg::W_RAW-1:0]  in_accel_x,
  input  wire logic signed [tcch_pkg::W_RAW-1:0]  in_accel_y,
  input  wire logic signed [tcch_pkg::W_RAW-1:0]  in_accel_z,
  input  wire logic signed [tcch_pkg::W_RAW-1:0]  in_magnet_x,
  input  wire logic signed [tcch_pkg::W_RAW-1:0]  in_magnet_y,
  input  wire logic signed [tcch_pkg::W_RAW-1:0]  in_magnet_z,
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [tcch_pkg::W_HEAD-1:0]             out_heading_q6,
  output logic                                    out_degenerate
);
  import tcch_pkg::*;

  logic en;

  // Configuration registers
  logic [W_BIAS-1:0]       acc_bias_r, mag_bias_r;
  logic signed [W_RAW-1:0] mag_min_r [3];
  logic signed [W_RAW-1:0] mag_max_r [3];

  // Stage 1
  logic signed [W_RAW-1:0] raw_a [3];
  logic signed [W_RAW-1:0] raw_m [3];
  logic signed [W_RAW-1:0] a_nxt [3];
  logic signed [W_RAW-1:0] mv_nxt [3];
  logic signed [W_NUM-1:0] num_nxt [3];
  logic signed [W_DEN-1:0] den_nxt [3];
  logic                    deg1_nxt;
  logic signed [W_RAW-1:0] a_s1_r [3];
  logic signed [W_NUM-1:0] num_s1_r [3];
  logic signed [W_DEN-1:0] den_s1_r [3];
  logic                    deg_s1_r;

  // Divider side chain and later stages
  side_t                    side_r [K_S1+1:K_Q];
  logic signed [W_RAW-1:0]  q [3];
  logic signed [W_RAW-1:0]  aq [3];
  logic signed [W_PROD-1:0] prod_r [6];
  side_t                    side_p_r;
  logic signed [W_C-1:0]    c_r [3];
  side_t                    side_c_r;
  logic signed [W_M-1:0]    m0_r, m1_r;
  logic signed [W_C-1:0]    c1_m_r;
  logic                     deg_m_r;
  logic signed [W_NY-1:0]   ny_r  [K_NY:K_AMAG];
  logic signed [W_C-1:0]    c1_r  [K_NY:K_AMAG];
  logic                     deg_r [K_NY:K_AMAG];
  logic [W_ROOT-1:0]        amag;
  logic signed [W_XY-1:0]   x_r, y_r;
  logic                     deg_xy_r;
  logic                     deg_cr;

  logic vld_r [K_S1:K_OUT];

  // Advance everything unless a finished word is held
  assign en       = !vld_r[K_OUT] || out_ready;
  assign in_ready = en;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_bias_r <= '0;
      mag_bias_r <= '0;
      for (int i = 0; i < 3; i++) begin
        mag_min_r[i] <= 16'sh8000;
        mag_max_r[i] <= 16'sh7fff;
      end
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        CFG_ACC_BIAS: acc_bias_r   <= cfg_wdata;
        CFG_MAG_BIAS: mag_bias_r   <= cfg_wdata;
        CFG_MIN_X:    mag_min_r[0] <= cfg_wdata[W_RAW-1:0];
        CFG_MIN_Y:    mag_min_r[1] <= cfg_wdata[W_RAW-1:0];
        CFG_MIN_Z:    mag_min_r[2] <= cfg_wdata[W_RAW-1:0];
        CFG_MAX_X:    mag_max_r[0] <= cfg_wdata[W_RAW-1:0];
        CFG_MAX_Y:    mag_max_r[1] <= cfg_wdata[W_RAW-1:0];
        CFG_MAX_Z:    mag_max_r[2] <= cfg_wdata[W_RAW-1:0];
        default: ;
      endcase
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = K_S1; k <= K_OUT; k++) vld_r[k] <= 1'b0;
    end else if (en) begin
      vld_r[K_S1] <= in_valid;
      for (int k = K_S1 + 1; k <= K_OUT; k++) vld_r[k] <= vld_r[k-1];
    end
  end

  // Remove biases, form span numerator and denominator
  always_comb begin
    raw_a[0] = in_accel_x;  raw_a[1] = in_accel_y;  raw_a[2] = in_accel_z;
    raw_m[0] = in_magnet_x; raw_m[1] = in_magnet_y; raw_m[2] = in_magnet_z;
    deg1_nxt = 1'b0;
    for (int i = 0; i < 3; i++) begin
      a_nxt[i]   = raw_a[i] - $signed(acc_bias_r[W_RAW*i +: W_RAW]);
      mv_nxt[i]  = raw_m[i] - $signed(mag_bias_r[W_RAW*i +: W_RAW]);
      num_nxt[i] = (W_NUM'(mv_nxt[i]) <<< 1) - W_NUM'(mag_min_r[i]) - W_NUM'(mag_max_r[i]);
      den_nxt[i] = W_DEN'(mag_max_r[i]) - W_DEN'(mag_min_r[i]);
      if (den_nxt[i] == '0) deg1_nxt = 1'b1;
    end
    if (a_nxt[0] == '0 && a_nxt[1] == '0 && a_nxt[2] == '0) deg1_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        a_s1_r[i]   <= a_nxt[i];
        num_s1_r[i] <= num_nxt[i];
        den_s1_r[i] <= den_nxt[i];
      end
      deg_s1_r <= deg1_nxt;
    end
  end

  // Span dividers, one per axis
  for (genvar i = 0; i < 3; i++) begin : g_div
    tcch_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_s1_r[i]),
      .den (den_s1_r[i]),
      .q   (q[i])
    );
  end

  // Magnitude of a, in parallel with the dividers
  tcch_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .ax   (a_s1_r[0]),
    .ay   (a_s1_r[1]),
    .az   (a_s1_r[2]),
    .root (amag)
  );

  // Carry a and the flag alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[K_S1+1] <= {a_s1_r[2], a_s1_r[1], a_s1_r[0], deg_s1_r};
      for (int k = K_S1 + 2; k <= K_Q; k++) side_r[k] <= side_r[k-1];
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) aq[i] = $signed(side_r[K_Q].a[i]);
  end

  // c = q x a: products, then differences
  always_ff @(posedge clk) begin
    if (en) begin
      prod_r[0] <= q[1] * aq[2];
      prod_r[1] <= q[2] * aq[1];
      prod_r[2] <= q[2] * aq[0];
      prod_r[3] <= q[0] * aq[2];
      prod_r[4] <= q[0] * aq[1];
      prod_r[5] <= q[1] * aq[0];
      side_p_r  <= side_r[K_Q];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c_r[0]   <= W_C'(prod_r[0]) - W_C'(prod_r[1]);
      c_r[1]   <= W_C'(prod_r[2]) - W_C'(prod_r[3]);
      c_r[2]   <= W_C'(prod_r[4]) - W_C'(prod_r[5]);
      side_c_r <= side_p_r;
    end
  end

  // North along y: a.z*c.x - a.x*c.z
  always_ff @(posedge clk) begin
    if (en) begin
      m0_r    <= $signed(side_c_r.a[2]) * c_r[0];
      m1_r    <= $signed(side_c_r.a[0]) * c_r[2];
      c1_m_r  <= c_r[1];
      deg_m_r <= side_c_r.deg || (c_r[0] == '0 && c_r[1] == '0 && c_r[2] == '0);
    end
  end

  // Form the difference, then hold until the root arrives
  always_ff @(posedge clk) begin
    if (en) begin
      ny_r[K_NY]  <= W_NY'(m0_r) - W_NY'(m1_r);
      c1_r[K_NY]  <= c1_m_r;
      deg_r[K_NY] <= deg_m_r;
      for (int k = K_NY + 1; k <= K_AMAG; k++) begin
        ny_r[k]  <= ny_r[k-1];
        c1_r[k]  <= c1_r[k-1];
        deg_r[k] <= deg_r[k-1];
      end
    end
  end

  // CORDIC operands X = -ny*256, Y = -c.y*|a|
  always_ff @(posedge clk) begin
    if (en) begin
      x_r      <= (-W_XY'(ny_r[K_AMAG])) <<< 8;
      y_r      <= -(c1_r[K_AMAG] * $signed({1'b0, amag}));
      deg_xy_r <= deg_r[K_AMAG];
    end
  end

  assign deg_cr = deg_xy_r || (x_r == '0 && y_r == '0);

  tcch_cordic u_cordic (
    .clk     (clk),
    .en      (en),
    .x       (x_r),
    .y       (y_r),
    .deg_in  (deg_cr),
    .heading (out_heading_q6),
    .deg_out (out_degenerate)
  );

  assign out_valid = vld_r[K_OUT];

  // Checks
  a_deg_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_heading_q6 == '0)
    else $error("degenerate result with nonzero heading");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> {1'b0, out_heading_q6} < TURN_Q6)
    else $error("heading out of range");

  a_rst_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    en && vld_r[K_OUT-1] |=> out_valid)
    else $error("word lost before output register");

endmodule
`default_nettype wire
